### design/xcr_pkg.sv
// Shared types and constants for the XMODEM checksum receiver.
// No dependencies; imported by every module of the block.
package xcr_pkg;

  localparam int BlockBytes = 128;
  localparam int CntW       = $clog2(BlockBytes + 1);
  localparam int CancelLen  = 9;
  localparam int CanLen     = 5;
  localparam int SeqW       = $clog2(CancelLen);

  localparam logic [7:0] ErrorLimitRst = 8'd20;

  localparam logic [7:0] ChSoh = 8'd1;
  localparam logic [7:0] ChEot = 8'd4;
  localparam logic [7:0] ChAck = 8'd6;
  localparam logic [7:0] ChBs  = 8'd8;
  localparam logic [7:0] ChNak = 8'd21;
  localparam logic [7:0] ChCan = 8'd24;

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_BYTE    = 2'd1,
    KIND_TIMEOUT = 2'd2
  } xcr_kind_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HUNT = 3'd1,
    PH_BLK  = 3'd2,
    PH_COMP = 3'd3,
    PH_DATA = 3'd4,
    PH_CSUM = 3'd5,
    PH_DONE = 3'd6
  } xcr_phase_e;

  typedef enum logic [1:0] {
    BS_NONE    = 2'd0,
    BS_COMMIT  = 2'd1,
    BS_DISCARD = 2'd2,
    BS_DUP     = 2'd3
  } xcr_bstat_e;

  typedef enum logic [2:0] {
    FS_RUNNING   = 3'd0,
    FS_COMPLETED = 3'd1,
    FS_CANCELLED = 3'd2,
    FS_TIMEOUTS  = 3'd3,
    FS_ERRORS    = 3'd4
  } xcr_fstat_e;

  typedef enum logic [1:0] {
    DESC_NONE   = 2'd0,
    DESC_SINGLE = 2'd1,
    DESC_CANCEL = 2'd2
  } xcr_desc_e;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic       data_valid;
    logic [7:0] data_byte;
    xcr_bstat_e block_status;
    xcr_fstat_e finish_status;
  } xcr_res_t;

  // For a cancel, res carries the block status of the first word and the
  // finish status of the final word.
  typedef struct packed {
    xcr_desc_e kind;
    xcr_res_t  res;
  } xcr_desc_t;

endpackage

### design/xmodem_checksum_receiver_unit.sv
// Top level of the XMODEM checksum receiver: input register, core, emitter.
// Depends on xcr_pkg, xcr_core and xcr_emit.
//
// Usage:
//   s_axis carries one event per word: tuser = kind (start, line byte,
//   timeout), tdata = the received line byte. m_axis carries the result
//   words; tlast marks the final word caused by one event. Events that
//   cause nothing produce no word.
//   cfg writes error_limit; write it only while the block is idle.
// Order: an event's first word reaches the output register through the input
//   register, then the result register, once the emitter takes the event.
// Throughput: one event per cycle while each event gives at most one word and
//   m_axis_tready is high. The cancel sequencer gives a cancel nine words, one
//   per cycle while it is high, holding off new events till its last is taken.
// Reset: the block is idle, waiting for a start event, error_limit is 20,
//   and no word is pending.
// Stall: when m_axis_tready is low the result word holds, one more event
//   waits in the input register, and then s_axis_tready drops.
module xmodem_checksum_receiver_unit import xcr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] send_byte, [15:8] data_byte,
                                      // [17:16] block_status, [20:18] finish_status
  output logic [1:0]  m_axis_tuser,   // [0] send_valid, [1] data_valid
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  logic       in_valid_q;
  logic [1:0] in_kind_q;
  logic [7:0] in_byte_q;
  logic [7:0] error_limit_q;
  logic       emit_ready;
  logic       fire;
  xcr_desc_t  desc;
  xcr_res_t   out_res;

  assign cfg_ready_o   = 1'b1;
  assign fire          = in_valid_q && emit_ready;
  assign s_axis_tready = !in_valid_q || emit_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      error_limit_q <= ErrorLimitRst;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        error_limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind_q <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  xcr_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .kind_i        (xcr_kind_e'(in_kind_q)),
    .byte_i        (in_byte_q),
    .error_limit_i (error_limit_q),
    .desc_o        (desc)
  );

  xcr_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (in_valid_q),
    .desc_i       (desc),
    .ready_o      (emit_ready),
    .out_valid_o  (m_axis_tvalid),
    .out_res_o    (out_res),
    .out_last_o   (m_axis_tlast),
    .out_ready_i  (m_axis_tready)
  );

  assign m_axis_tdata = {3'b000, out_res.finish_status, out_res.block_status,
                         out_res.data_byte, out_res.send_byte};
  assign m_axis_tuser = {out_res.data_valid, out_res.send_valid};

  a_cancel_runs_on : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("cancel sequence broke off before its final word");

  a_cancel_sends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[0] && !m_axis_tuser[1])
    else $error("non-final word is not a reply byte");

  a_one_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("word carries both a reply and a payload byte");

  a_stall_holds_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !emit_ready |=> in_valid_q && $stable(in_byte_q))
    else $error("pending event lost while the emitter was busy");

endmodule

### design/xcr_core.sv
// Protocol state and per-event decision logic of the XMODEM receiver.
// Depends on xcr_pkg; feeds a result descriptor to xcr_emit.
module xcr_core import xcr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  xcr_kind_e  kind_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] error_limit_i,
  output xcr_desc_t  desc_o
);

  xcr_phase_e      phase_q, phase_d;
  logic [7:0]      last_good_q, last_good_d;
  logic [7:0]      hdr_q, hdr_d;
  logic [7:0]      sum_q, sum_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      err_q, err_d;
  logic            bad_q, bad_d;

  logic [7:0]  expected;
  logic        in_frame;
  logic        err_req;
  xcr_bstat_e  err_bs;
  xcr_fstat_e  err_fs;
  logic [8:0]  err_next;
  logic        hdr_ok;

  always_comb begin
    expected = last_good_q + 8'd1;
    in_frame = (phase_q == PH_BLK) || (phase_q == PH_COMP) ||
               (phase_q == PH_DATA) || (phase_q == PH_CSUM);
    hdr_ok   = !bad_q && (hdr_q == expected);
    err_next = {1'b0, err_q} + 9'd1;

    phase_d     = phase_q;
    last_good_d = last_good_q;
    hdr_d       = hdr_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    err_d       = err_q;
    bad_d       = bad_q;
    err_req     = 1'b0;
    err_bs      = BS_NONE;
    err_fs      = FS_RUNNING;
    desc_o      = '0;

    if (fire_i) begin
      case (kind_i)
        KIND_START: begin
          last_good_d = '0;
          hdr_d       = '0;
          sum_d       = '0;
          cnt_d       = '0;
          err_d       = '0;
          bad_d       = 1'b0;
          phase_d     = PH_HUNT;
          desc_o.kind = DESC_SINGLE;
          desc_o.res.send_valid   = 1'b1;
          desc_o.res.send_byte    = ChNak;
          desc_o.res.block_status = in_frame ? BS_DISCARD : BS_NONE;
        end
        KIND_TIMEOUT: begin
          if (phase_q != PH_IDLE && phase_q != PH_DONE) begin
            err_req = 1'b1;
            err_bs  = in_frame ? BS_DISCARD : BS_NONE;
            err_fs  = FS_TIMEOUTS;
          end
        end
        KIND_BYTE: begin
          unique case (phase_q)
            PH_HUNT: begin
              if (byte_i == ChSoh) begin
                phase_d = PH_BLK;
                bad_d   = 1'b0;
                sum_d   = '0;
                cnt_d   = '0;
              end else if (byte_i == ChEot) begin
                phase_d     = PH_DONE;
                desc_o.kind = DESC_SINGLE;
                desc_o.res.send_valid    = 1'b1;
                desc_o.res.send_byte     = ChAck;
                desc_o.res.finish_status = FS_COMPLETED;
              end else if (byte_i == ChCan) begin
                phase_d     = PH_DONE;
                desc_o.kind = DESC_CANCEL;
                desc_o.res.finish_status = FS_CANCELLED;
              end
            end
            PH_BLK: begin
              hdr_d   = byte_i;
              phase_d = PH_COMP;
            end
            PH_COMP: begin
              if ((hdr_q + byte_i) != 8'hff ||
                  (hdr_q != expected && hdr_q != last_good_q)) begin
                bad_d = 1'b1;
              end
              cnt_d   = '0;
              sum_d   = '0;
              phase_d = PH_DATA;
            end
            PH_DATA: begin
              sum_d = sum_q + byte_i;
              cnt_d = cnt_q + CntW'(1);
              if (cnt_d >= CntW'(BlockBytes)) begin
                phase_d = PH_CSUM;
              end
              if (hdr_ok) begin
                desc_o.kind = DESC_SINGLE;
                desc_o.res.data_valid = 1'b1;
                desc_o.res.data_byte  = byte_i;
              end
            end
            PH_CSUM: begin
              phase_d = PH_HUNT;
              if (hdr_ok && sum_q == byte_i) begin
                last_good_d = hdr_q;
                err_d       = '0;
                desc_o.kind = DESC_SINGLE;
                desc_o.res.send_valid   = 1'b1;
                desc_o.res.send_byte    = ChAck;
                desc_o.res.block_status = BS_COMMIT;
              end else if (!bad_q && !hdr_ok) begin
                desc_o.kind = DESC_SINGLE;
                desc_o.res.send_valid   = 1'b1;
                desc_o.res.send_byte    = ChAck;
                desc_o.res.block_status = BS_DUP;
              end else begin
                err_req = 1'b1;
                err_bs  = BS_DISCARD;
                err_fs  = FS_ERRORS;
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase

      if (err_req) begin
        if (err_next >= {1'b0, error_limit_i}) begin
          phase_d     = PH_DONE;
          desc_o.kind = DESC_CANCEL;
          desc_o.res.block_status  = err_bs;
          desc_o.res.finish_status = err_fs;
        end else begin
          err_d       = err_next[7:0];
          phase_d     = PH_HUNT;
          desc_o.kind = DESC_SINGLE;
          desc_o.res.send_valid   = 1'b1;
          desc_o.res.send_byte    = ChNak;
          desc_o.res.block_status = err_bs;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      last_good_q <= '0;
      hdr_q       <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      err_q       <= '0;
      bad_q       <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      last_good_q <= last_good_d;
      hdr_q       <= hdr_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      bad_q       <= bad_d;
    end
  end

endmodule

### design/xcr_emit.sv
// Result register and cancel sequencer: turns a descriptor into 0, 1 or 9 words.
// Depends on xcr_pkg; driven by xcr_core through the top level.
module xcr_emit import xcr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      desc_valid_i,
  input  xcr_desc_t desc_i,
  output logic      ready_o,
  output logic      out_valid_o,
  output xcr_res_t  out_res_o,
  output logic      out_last_o,
  input  logic      out_ready_i
);

  logic            valid_q, valid_d;
  xcr_res_t        res_q, res_d;
  logic            last_q, last_d;
  logic [SeqW-1:0] seq_q, seq_d;
  xcr_fstat_e      fs_q, fs_d;

  function automatic xcr_res_t cancel_word(logic [SeqW-1:0] k, xcr_bstat_e bs,
                                           xcr_fstat_e fs);
    xcr_res_t r;
    r            = '0;
    r.send_valid = 1'b1;
    r.send_byte  = (k < SeqW'(CanLen)) ? ChCan : ChBs;
    r.block_status  = (k == '0) ? bs : BS_NONE;
    r.finish_status = (k == SeqW'(CancelLen - 1)) ? fs : FS_RUNNING;
    return r;
  endfunction

  assign ready_o = !valid_q || (out_ready_i && last_q);

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    last_d  = last_q;
    seq_d   = seq_q;
    fs_d    = fs_q;

    if (valid_q && out_ready_i) begin
      if (!last_q) begin
        seq_d  = seq_q + SeqW'(1);
        res_d  = cancel_word(seq_d, BS_NONE, fs_q);
        last_d = (seq_d == SeqW'(CancelLen - 1));
      end else begin
        valid_d = 1'b0;
      end
    end

    if (desc_valid_i && ready_o) begin
      unique case (desc_i.kind)
        DESC_SINGLE: begin
          valid_d = 1'b1;
          res_d   = desc_i.res;
          last_d  = 1'b1;
        end
        DESC_CANCEL: begin
          valid_d = 1'b1;
          seq_d   = '0;
          fs_d    = desc_i.res.finish_status;
          res_d   = cancel_word('0, desc_i.res.block_status, desc_i.res.finish_status);
          last_d  = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      last_q  <= 1'b0;
      seq_q   <= '0;
    end else begin
      valid_q <= valid_d;
      last_q  <= last_d;
      seq_q   <= seq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    fs_q  <= fs_d;
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;
  assign out_last_o  = last_q;

endmodule

### sim/xmodem_checksum_receiver_unit_test.sv
// Self-checking testbench for the XMODEM checksum receiver unit.
// A scoreboard class predicts every reply word; plain tasks drive the event
// stream and the error_limit channel, and an initial block drives the result ready. Depends on xcr_pkg and the unit.
`timescale 1ns / 100ps

module xmodem_checksum_receiver_unit_test;
  import xcr_pkg::*;

  localparam logic [1:0] KindUnused = 2'd3;

  typedef struct packed {
    logic     last;
    xcr_res_t res;
  } reply_word_t;

  class rx_reply_tracker;
    logic [7:0]  limit;
    xcr_phase_e  ph;
    logic [7:0]  last_good;
    logic [7:0]  hdr;
    logic [7:0]  sum;
    int          cnt;
    logic [7:0]  err_cnt;
    logic        bad;
    reply_word_t due_words[$];
    int          n_items;
    int          n_words;
    int          n_commit;
    int          n_dup;
    int          n_cancel;
    int          n_bad;

    function new();
      limit     = ErrorLimitRst;
      ph        = PH_IDLE;
      last_good = '0;
      hdr       = '0;
      sum       = '0;
      cnt       = 0;
      err_cnt   = '0;
      bad       = 1'b0;
      n_items   = 0;
      n_words   = 0;
      n_commit  = 0;
      n_dup     = 0;
      n_cancel  = 0;
      n_bad     = 0;
    endfunction

    function void add(logic sv, logic [7:0] sb, logic dv, logic [7:0] db,
                      xcr_bstat_e bs, xcr_fstat_e fs);
      reply_word_t w;
      w.last              = 1'b0;
      w.res.send_valid    = sv;
      w.res.send_byte     = sb;
      w.res.data_valid    = dv;
      w.res.data_byte     = db;
      w.res.block_status  = bs;
      w.res.finish_status = fs;
      due_words.push_back(w);
    endfunction

    function bit in_frame();
      return ph >= PH_BLK && ph <= PH_CSUM;
    endfunction

    function void cancel(xcr_bstat_e bs, xcr_fstat_e fs);
      xcr_bstat_e b;
      xcr_fstat_e f;
      for (int k = 0; k < CancelLen; k++) begin
        b = BS_NONE;
        f = FS_RUNNING;
        if (k == 0) b = bs;
        if (k == CancelLen - 1) f = fs;
        add(1'b1, (k < CanLen) ? ChCan : ChBs, 1'b0, 8'h00, b, f);
      end
      ph = PH_DONE;
      n_cancel++;
    endfunction

    function void count_error(xcr_bstat_e bs, xcr_fstat_e fs);
      int nxt;
      nxt = int'(err_cnt) + 1;
      if (nxt >= int'(limit)) begin
        cancel(bs, fs);
      end else begin
        err_cnt = 8'(nxt);
        ph = PH_HUNT;
        add(1'b1, ChNak, 1'b0, 8'h00, bs, FS_RUNNING);
      end
    endfunction

    function void react(logic [1:0] kind, logic [7:0] b);
      logic [7:0] want;
      xcr_bstat_e bs;
      want = last_good + 8'd1;
      bs = in_frame() ? BS_DISCARD : BS_NONE;
      case (kind)
        KIND_START: begin
          last_good = '0;
          hdr       = '0;
          sum       = '0;
          cnt       = 0;
          err_cnt   = '0;
          bad       = 1'b0;
          ph        = PH_HUNT;
          add(1'b1, ChNak, 1'b0, 8'h00, bs, FS_RUNNING);
        end
        KIND_TIMEOUT: begin
          if (ph != PH_IDLE && ph != PH_DONE) count_error(bs, FS_TIMEOUTS);
        end
        KIND_BYTE: begin
          case (ph)
            PH_HUNT: begin
              if (b == ChSoh) begin
                ph  = PH_BLK;
                bad = 1'b0;
                sum = '0;
                cnt = 0;
              end else if (b == ChEot) begin
                ph = PH_DONE;
                add(1'b1, ChAck, 1'b0, 8'h00, BS_NONE, FS_COMPLETED);
              end else if (b == ChCan) begin
                cancel(BS_NONE, FS_CANCELLED);
              end
            end
            PH_BLK: begin
              hdr = b;
              ph  = PH_COMP;
            end
            PH_COMP: begin
              if (8'(hdr + b) != 8'hFF || (hdr != want && hdr != last_good)) bad = 1'b1;
              cnt = 0;
              sum = '0;
              ph  = PH_DATA;
            end
            PH_DATA: begin
              sum = sum + b;
              cnt++;
              if (cnt >= BlockBytes) ph = PH_CSUM;
              if (!bad && hdr == want) add(1'b0, 8'h00, 1'b1, b, BS_NONE, FS_RUNNING);
            end
            PH_CSUM: begin
              ph = PH_HUNT;
              if (!bad && hdr == want) begin
                if (sum == b) begin
                  last_good = hdr;
                  err_cnt   = '0;
                  add(1'b1, ChAck, 1'b0, 8'h00, BS_COMMIT, FS_RUNNING);
                  n_commit++;
                end else begin
                  count_error(BS_DISCARD, FS_ERRORS);
                end
              end else if (!bad) begin
                add(1'b1, ChAck, 1'b0, 8'h00, BS_DUP, FS_RUNNING);
                n_dup++;
              end else begin
                count_error(BS_DISCARD, FS_ERRORS);
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    endfunction

    function void log_event(logic [1:0] kind, logic [7:0] b);
      int n0;
      reply_word_t w;
      n0 = due_words.size();
      n_items++;
      react(kind, b);
      if (due_words.size() > n0) begin
        w = due_words.pop_back();
        w.last = 1'b1;
        due_words.push_back(w);
      end
    endfunction

    function void match_word(logic [23:0] d, logic [1:0] u, logic l);
      reply_word_t w;
      n_words++;
      if (due_words.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("%0t: unexpected word tdata=%06h tuser=%0d tlast=%0d", $realtime, d, u, l);
        return;
      end
      w = due_words.pop_front();
      if (u[0] !== w.res.send_valid || d[7:0] !== w.res.send_byte ||
          u[1] !== w.res.data_valid || d[15:8] !== w.res.data_byte ||
          d[17:16] !== w.res.block_status || d[20:18] !== w.res.finish_status ||
          d[23:21] !== 3'b000 || l !== w.last) begin
        n_bad++;
        if (n_bad <= 10)
          $display("%0t: mismatch exp sv=%0d sb=%02h dv=%0d db=%02h bs=%0d fs=%0d last=%0d",
                   $realtime, w.res.send_valid, w.res.send_byte, w.res.data_valid,
                   w.res.data_byte, w.res.block_status, w.res.finish_status, w.last);
        if (n_bad <= 10)
          $display("%0t:          got sv=%0d sb=%02h dv=%0d db=%02h bs=%0d fs=%0d last=%0d pad=%0d",
                   $realtime, u[0], d[7:0], u[1], d[15:8], d[17:16], d[20:18], l, d[23:21]);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic [1:0]  s_axis_tuser = 2'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i = 8'h00;

  int idle_pct = 0;
  int stall_pct = 0;

  rx_reply_tracker trk = new();

  xmodem_checksum_receiver_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    #18_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready)
        trk.match_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_event(input logic [1:0] kind, input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    trk.log_event(kind, b);
  endtask

  // Hold the sender until every predicted word has come, then let the pipe empty.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (trk.due_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [7:0] v);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    trk.limit = v;
  endtask

  task automatic send_frame();
    logic [7:0] blk, comp, sum, off, v;
    int r, cut, fill;
    if (trk.ph != PH_HUNT) send_event(KIND_START, 8'($urandom_range(255)));
    r = $urandom_range(99);
    if (r < 70) blk = trk.last_good + 8'd1;
    else if (r < 85) blk = trk.last_good;
    else blk = 8'($urandom_range(255));
    comp = ~blk;
    if ($urandom_range(9) == 0) comp = comp ^ 8'($urandom_range(1, 255));
    off = ($urandom_range(4) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
    cut = ($urandom_range(3) == 0) ? $urandom_range(BlockBytes + 2) : BlockBytes + 3;
    fill = $urandom_range(7);
    sum = 8'h00;
    send_event(KIND_BYTE, ChSoh);
    for (int i = 0; i < cut; i++) begin
      if (i == 0) begin
        v = blk;
      end else if (i == 1) begin
        v = comp;
      end else if (i < BlockBytes + 2) begin
        v = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom_range(255));
        sum = sum + v;
      end else begin
        v = sum + off;
      end
      send_event(KIND_BYTE, v);
    end
    if (cut <= BlockBytes + 2) begin
      if ($urandom_range(3) == 0) send_event(KIND_START, 8'($urandom_range(255)));
      else send_event(KIND_TIMEOUT, 8'($urandom_range(255)));
    end
  endtask

  task automatic send_noise();
    int r;
    logic [7:0] b;
    r = $urandom_range(99);
    b = 8'($urandom_range(255));
    if (r < 30) send_event(KIND_TIMEOUT, b);
    else if (r < 65) send_event(KIND_BYTE, b);
    else if (r < 73) send_event(KIND_BYTE, ChEot);
    else if (r < 80) send_event(KIND_BYTE, ChCan);
    else if (r < 90) send_event(KIND_START, b);
    else send_event(KindUnused, b);
  endtask

  task automatic run_phase(input logic [7:0] lim, input int idle, input int stall,
                           input int quota);
    int base;
    write_limit(lim);
    idle_pct  = idle;
    stall_pct = stall;
    base = trk.n_items;
    while (trk.n_items - base < quota) begin
      if (quota - (trk.n_items - base) >= BlockBytes + 5 && $urandom_range(99) < 50)
        send_frame();
      else repeat ($urandom_range(1, 3)) send_noise();
      if ($urandom_range(11) == 0) settle();
    end
    settle();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_event(KIND_BYTE, 8'hFF);
    send_event(KIND_TIMEOUT, 8'h00);
    send_event(KindUnused, 8'hFF);
    send_event(KIND_START, 8'h00);
    send_event(KIND_BYTE, 8'h00);
    send_event(KIND_BYTE, 8'hFF);
    send_event(KIND_BYTE, ChSoh);
    send_event(KIND_TIMEOUT, 8'hFF);
    send_event(KIND_BYTE, ChSoh);
    send_event(KIND_BYTE, 8'h01);
    send_event(KIND_START, 8'hFF);
    send_event(KIND_BYTE, ChCan);
    send_event(KIND_BYTE, ChSoh);
    send_event(KIND_TIMEOUT, 8'h00);
    send_event(KIND_START, 8'h00);
    send_event(KIND_BYTE, ChEot);
    write_limit(8'd1);
    send_event(KIND_START, 8'h00);
    send_event(KIND_TIMEOUT, 8'h00);
    send_event(KIND_START, 8'h00);
    send_event(KIND_BYTE, ChSoh);
    send_event(KIND_BYTE, 8'h01);
    send_event(KIND_BYTE, 8'hFE);
    send_event(KIND_BYTE, 8'h00);
    send_event(KIND_BYTE, 8'hFF);
    send_event(KIND_TIMEOUT, 8'hFF);

    run_phase(8'd3, 0, 0, 30);
    run_phase(8'd255, 86, 0, 30);
    run_phase(8'd2, 0, 86, 145);
    run_phase(ErrorLimitRst, 27, 27, 30);
    settle();

    $display("Covered %0d events and %0d reply words under error limits 1 to 255:",
             trk.n_items, trk.n_words);
    $display("  %0d blocks committed, %0d duplicates, %0d cancels, %0d mismatches",
             trk.n_commit, trk.n_dup, trk.n_cancel, trk.n_bad);
    if (trk.n_bad == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
